[hw/rtl/mrbm_pkg.sv]
package mrbm_pkg;

   // result field
   localparam int AREA_W = 17;
   localparam logic [AREA_W-1:0] AREA_MAX = '1;

   // column_count register
   localparam int CSR_W = 7;
   localparam logic [CSR_W-1:0] CSR_RESET = 7'd64;

   typedef logic [AREA_W-1:0] area_type;
   typedef logic [CSR_W-1:0]  csr_type;

endpackage

[hw/rtl/mrbm_ram.sv]
// Simple dual-port RAM, one write and one registered read per cycle.
module mrbm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/max_rectangle_binary_matrix_top.sv]
// Channel  Direction  Handshake              Payload
// -------  ---------  ---------------------  ----------------------------------------
// req      in         req_tvalid/req_tready  req_tdata[0] cell_req, req_tlast last_cell
// rsp      out        rsp_tvalid/rsp_tready  rsp_tdata[16:0] largest_area
// csr      in         csr_valid/csr_ready    csr_data column_count (always ready)
//
// A cell passes the height RAM read and the compare/push, plus a pop with stack RAM
// re-read per bar popped. A row end pops every bar left via re-read and flush states.
// After the last cell's hand-off, a sweep over all MAX_COLUMNS entries zeroes the
// height RAM; the same sweep runs after reset. No cell is taken during it.
// A result waiting on rsp stalls only the next last cell; all other cells flow.
module max_rectangle_binary_matrix_top #(
   parameter int MAX_COLUMNS = 64,
   parameter int MAX_ROWS    = 1024
) (
   input  logic        clock,
   input  logic        reset,
   // cell transfer
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [0] cell_req, [7:1] zero
   input  logic        req_tlast,   // last_cell
   // result transfer
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [16:0] largest_area, [23:17] zero
   // column_count write
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [6:0]  csr_data     // column_count
);

   localparam int CW   = $clog2(MAX_COLUMNS);      // column index
   localparam int FW   = $clog2(MAX_COLUMNS + 1);  // stack fill / bar width
   localparam int HW   = $clog2(MAX_ROWS + 1);     // run height
   localparam int SW   = CW + HW;                  // stack entry
   localparam int CNTW = (FW > mrbm_pkg::CSR_W) ? FW : mrbm_pkg::CSR_W;
   localparam int PW   = (HW + FW > mrbm_pkg::AREA_W) ? HW + FW : mrbm_pkg::AREA_W;

   localparam logic [2:0] S_IDLE  = 3'd0;  // wait for a cell
   localparam logic [2:0] S_HGT   = 3'd1;  // height update
   localparam logic [2:0] S_CMP   = 3'd2;  // pop or push against stack top
   localparam logic [2:0] S_RDC   = 3'd3;  // stack re-read after pop
   localparam logic [2:0] S_RDF   = 3'd4;  // stack re-read during flush
   localparam logic [2:0] S_FLUSH = 3'd5;  // row-end drain
   localparam logic [2:0] S_DONE  = 3'd6;  // hand result to rsp
   localparam logic [2:0] S_CLR   = 3'd7;  // height RAM sweep

   logic [2:0]              state_ff, state_in;
   logic [CW-1:0]           pos_ff, pos_in;
   logic [CW-1:0]           clr_ptr_ff, clr_ptr_in;
   logic [FW-1:0]           fill_ff, fill_in;
   logic [CW-1:0]           start_ff, start_in;
   logic [HW-1:0]           h_ff, h_in;
   logic                    cell_ff, cell_in;
   logic                    last_ff, last_in;
   mrbm_pkg::area_type      best_ff, best_in;
   mrbm_pkg::csr_type       cols_ff;
   logic                    rsp_valid_ff, rsp_valid_in;
   mrbm_pkg::area_type      rsp_area_ff, rsp_area_in;

   // height RAM
   logic                    hgt_wr_en;
   logic [CW-1:0]           hgt_wr_addr;
   logic [HW-1:0]           hgt_wr_data;
   logic [HW-1:0]           hgt_rd_data;
   // stack RAM, entry = {start column, bar height}
   logic                    stk_wr_en;
   logic [SW-1:0]           stk_rd_data;
   logic [CW-1:0]           top_start;
   logic [HW-1:0]           top_h;

   logic [CNTW-1:0]         cols_eff;
   logic [CNTW-1:0]         pos_next;
   logic                    row_end;
   logic [FW-1:0]           bar_width;
   logic [PW-1:0]           product;
   mrbm_pkg::area_type      area_sat;
   logic                    req_fire;

   assign csr_ready = 1'b1;
   assign req_tready = (state_ff == S_IDLE);
   assign req_fire = req_tvalid & req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cols_ff <= mrbm_pkg::CSR_RESET;
      end else if (csr_valid & csr_ready) begin
         cols_ff <= csr_data;
      end
   end

   mrbm_ram #(.WIDTH(HW), .DEPTH(MAX_COLUMNS)) u_hgt_ram (
      .clock   (clock),
      .wr_en   (hgt_wr_en),
      .wr_addr (hgt_wr_addr),
      .wr_data (hgt_wr_data),
      .rd_addr (pos_ff),
      .rd_data (hgt_rd_data)
   );

   // read port always addresses the current top: fill - 1
   mrbm_ram #(.WIDTH(SW), .DEPTH(MAX_COLUMNS)) u_stk_ram (
      .clock   (clock),
      .wr_en   (stk_wr_en),
      .wr_addr (fill_ff[CW-1:0]),
      .wr_data ({start_ff, h_ff}),
      .rd_addr (CW'(fill_ff - FW'(1))),
      .rd_data (stk_rd_data)
   );

   assign top_start = stk_rd_data[SW-1:HW];
   assign top_h     = stk_rd_data[HW-1:0];

   assign hgt_wr_en   = (state_ff == S_HGT) || (state_ff == S_CLR);
   assign hgt_wr_addr = (state_ff == S_CLR) ? clr_ptr_ff : pos_ff;
   assign hgt_wr_data = (state_ff == S_CLR) ? '0 : h_in;

   // column count: zero means one, clamp to MAX_COLUMNS
   always_comb begin
      cols_eff = CNTW'(cols_ff);
      if (cols_eff == '0) begin
         cols_eff = CNTW'(1);
      end else if (cols_eff > CNTW'(MAX_COLUMNS)) begin
         cols_eff = CNTW'(MAX_COLUMNS);
      end
   end

   assign pos_next = CNTW'(pos_ff) + CNTW'(1);
   assign row_end  = (pos_next >= cols_eff) || last_ff;

   // area of the popped bar; width ends at pos (mid-row) or pos + 1 (row end)
   assign bar_width = (state_ff == S_FLUSH) ? FW'(pos_ff) + FW'(1) - FW'(top_start)
                                            : FW'(pos_ff) - FW'(top_start);
   assign product   = PW'(top_h) * PW'(bar_width);
   assign area_sat  = (product > PW'(mrbm_pkg::AREA_MAX)) ? mrbm_pkg::AREA_MAX
                                                          : mrbm_pkg::AREA_W'(product);

   always_comb begin
      state_in     = state_ff;
      pos_in       = pos_ff;
      clr_ptr_in   = clr_ptr_ff;
      fill_in      = fill_ff;
      start_in     = start_ff;
      h_in         = h_ff;
      cell_in      = cell_ff;
      last_in      = last_ff;
      best_in      = best_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_area_in  = rsp_area_ff;
      stk_wr_en    = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               cell_in  = req_tdata[0];
               last_in  = req_tlast;
               state_in = S_HGT;
            end
         end
         S_HGT: begin
            if (!cell_ff) begin
               h_in = '0;
            end else if (hgt_rd_data < HW'(MAX_ROWS)) begin
               h_in = hgt_rd_data + HW'(1);
            end else begin
               h_in = hgt_rd_data;
            end
            start_in = pos_ff;
            state_in = S_CMP;
         end
         S_CMP: begin
            if ((fill_ff != '0) && (top_h > h_ff)) begin
               // taller bar ends here; the lower bar inherits its start
               fill_in  = fill_ff - FW'(1);
               start_in = top_start;
               if (area_sat > best_ff) begin
                  best_in = area_sat;
               end
               state_in = S_RDC;
            end else begin
               if (((fill_ff == '0) || (top_h < h_ff)) && (fill_ff < FW'(MAX_COLUMNS))) begin
                  stk_wr_en = 1'b1;
                  fill_in   = fill_ff + FW'(1);
               end
               if (row_end) begin
                  state_in = S_RDF;
               end else begin
                  pos_in   = CW'(pos_next);
                  state_in = S_IDLE;
               end
            end
         end
         S_RDC: begin
            state_in = S_CMP;
         end
         S_RDF: begin
            state_in = S_FLUSH;
         end
         S_FLUSH: begin
            if (fill_ff != '0) begin
               fill_in = fill_ff - FW'(1);
               if (area_sat > best_ff) begin
                  best_in = area_sat;
               end
               state_in = S_RDF;
            end else begin
               pos_in   = '0;
               state_in = last_ff ? S_DONE : S_IDLE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_area_in  = best_ff;
               best_in      = '0;
               fill_in      = '0;
               pos_in       = '0;
               clr_ptr_in   = '0;
               state_in     = S_CLR;
            end
         end
         S_CLR: begin
            clr_ptr_in = clr_ptr_ff + CW'(1);
            if (clr_ptr_ff == CW'(MAX_COLUMNS - 1)) begin
               state_in = S_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLR;
         pos_ff       <= '0;
         clr_ptr_ff   <= '0;
         fill_ff      <= '0;
         best_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         clr_ptr_ff   <= clr_ptr_in;
         fill_ff      <= fill_in;
         best_ff      <= best_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      start_ff    <= start_in;
      h_ff        <= h_in;
      cell_ff     <= cell_in;
      last_ff     <= last_in;
      rsp_area_ff <= rsp_area_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(24 - mrbm_pkg::AREA_W)'(0), rsp_area_ff};

   // stack never holds more bars than columns
   assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FW'(MAX_COLUMNS))
      else $error("stack fill above column count");

   // a result only appears out of the hand-off state
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_DONE))
      else $error("result raised outside hand-off");

   // an accepted cell always starts with the height update
   assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff == S_HGT))
      else $error("accepted cell not processed");

   // hand-off never overwrites a pending result
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE) && rsp_valid_ff && !rsp_tready |=> (state_ff == S_DONE))
      else $error("pending result overwritten");

   // column position stays inside the height RAM
   assert property (@(posedge clock) disable iff (reset)
      CNTW'(pos_ff) < CNTW'(MAX_COLUMNS))
      else $error("column position out of range");

endmodule

[bench/max_rectangle_binary_matrix_top_tb.sv]
`timescale 1ns / 100ps

module max_rectangle_binary_matrix_top_tb;

   localparam int COLUMNS = 64;
   localparam int ROWS    = 1024;
   // worst cell: full stack popped mid-row plus a full flush at row end, plus the clear sweep
   localparam int SETTLE_CYCLES = 4 * COLUMNS + 2 * COLUMNS + 16;
   localparam int HOLD_CYCLES   = 400;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;    // [0] cell_req, [7:1] zero
   logic        req_tlast = 1'b0;  // last_cell
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;         // [16:0] largest_area, [23:17] zero
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   mrbm_pkg::csr_type csr_data = '0;  // column_count

   max_rectangle_binary_matrix_top #(
      .MAX_COLUMNS(COLUMNS),
      .MAX_ROWS   (ROWS)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tlast (req_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Predictor: per-column run heights and a monotonic bar stack per row
   // ---------------------------------------------------------------------
   logic [10:0] run_height [COLUMNS];
   logic [5:0]  bar_left   [COLUMNS];   // start column of each bar
   logic [10:0] bar_tall   [COLUMNS];   // height of each bar
   int unsigned bar_depth;
   int unsigned next_col;
   mrbm_pkg::area_type best_so_far;
   mrbm_pkg::csr_type  cols_reg;

   mrbm_pkg::area_type expected_areas [$];
   int       failures = 0;

   // knobs for the sender and the receiver
   int sender_idle_pct = 0;
   int rsp_stall_pct   = 0;
   int hold_len        = 0;
   bit hold_go         = 1'b0;

   function automatic void clear_profile();
      foreach (run_height[i]) run_height[i] = '0;
      bar_depth   = 0;
      next_col    = 0;
      best_so_far = '0;
   endfunction

   function automatic void raise_best(int unsigned tall, int unsigned wide);
      longint unsigned area;
      area = longint'(tall) * wide;
      if (area > mrbm_pkg::AREA_MAX) area = mrbm_pkg::AREA_MAX;
      if (area > best_so_far) best_so_far = mrbm_pkg::area_type'(area);
   endfunction

   // cells in use per row; zero means one, anything past the array means all of it
   function automatic int unsigned active_columns(mrbm_pkg::csr_type value);
      if (value == 0) return 1;
      if (value > COLUMNS) return COLUMNS;
      return 32'(value);
   endfunction

   function automatic void track_rectangles(bit filled, bit last);
      int unsigned cols;
      int unsigned pos;
      int unsigned h;
      int unsigned start;
      cols = active_columns(cols_reg);
      pos  = (next_col >= COLUMNS) ? COLUMNS - 1 : next_col;
      if (filled) h = (run_height[pos] < ROWS) ? run_height[pos] + 1 : run_height[pos];
      else        h = 0;
      run_height[pos] = 11'(h);

      // lower height: pop taller bars, the new bar inherits the leftmost start
      start = pos;
      while (bar_depth > 0 && bar_tall[bar_depth-1] > h) begin
         bar_depth--;
         raise_best(bar_tall[bar_depth], pos - bar_left[bar_depth]);
         start = bar_left[bar_depth];
      end
      // equal height merges into the bar on top
      if ((bar_depth == 0 || bar_tall[bar_depth-1] < h) && bar_depth < COLUMNS) begin
         bar_left[bar_depth] = 6'(start);
         bar_tall[bar_depth] = 11'(h);
         bar_depth++;
      end

      // row end, possibly early because of a lowered count or a last cell
      if (pos + 1 >= cols || last) begin
         while (bar_depth > 0) begin
            bar_depth--;
            raise_best(bar_tall[bar_depth], pos + 1 - bar_left[bar_depth]);
         end
         next_col = 0;
      end else begin
         next_col = pos + 1;
      end

      if (last) begin
         expected_areas.push_back(best_so_far);
         clear_profile();
      end
   endfunction

   // ---------------------------------------------------------------------
   // Result side: random stalls plus an occasional long hold-off
   // ---------------------------------------------------------------------
   int hold_left = 0;
   bit hold_seen = 1'b0;

   always @(negedge clock) begin
      if (hold_go != hold_seen) begin
         hold_seen = hold_go;
         hold_left = hold_len;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // each result transfer is checked against the oldest expected area
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_areas.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual largest_area %0d",
                     $time, rsp_tdata[mrbm_pkg::AREA_W-1:0]);
            failures++;
         end else if (rsp_tdata[mrbm_pkg::AREA_W-1:0] !== expected_areas[0]) begin
            $display("%0t: largest_area mismatch, expected %0d, actual %0d",
                     $time, expected_areas[0], rsp_tdata[mrbm_pkg::AREA_W-1:0]);
            failures++;
            void'(expected_areas.pop_front());
         end else begin
            void'(expected_areas.pop_front());
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------
   // one cell transfer, with random idle cycles ahead of it
   task automatic offer_cell(input bit filled, input bit last);
      @(negedge clock);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {7'd0, filled};
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      track_rectangles(filled, last);
   endtask

   // stop offering, wait for every expected area, then let a cell still in flight finish
   task automatic settle_block();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (expected_areas.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_column_count(input mrbm_pkg::csr_type value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      cols_reg = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic send_matrix(input int unsigned cols, inout int sent);
      int unsigned rows;
      int unsigned total;
      int          density;
      rows  = $urandom_range(1, (48 / cols > 1) ? 48 / cols : 1);
      total = rows * cols;
      // broken matrices: last cell somewhere inside a row
      if ($urandom_range(99) < 12) total = $urandom_range(1, total);
      case ($urandom_range(3))
         0:       density = 100;
         1:       density = 90;
         default: density = $urandom_range(0, 100);
      endcase
      for (int unsigned i = 0; i < total; i++)
         offer_cell($urandom_range(99) < density, i == total - 1);
      sent += total;
   endtask

   function automatic mrbm_pkg::csr_type pick_column_count();
      int r;
      r = $urandom_range(99);
      if (r < 60) return mrbm_pkg::csr_type'($urandom_range(1, 8));
      if (r < 85) return mrbm_pkg::csr_type'($urandom_range(9, 24));
      if (r < 93) return mrbm_pkg::csr_type'($urandom_range(25, COLUMNS));
      if (r < 96) return '0;
      return mrbm_pkg::csr_type'($urandom_range(COLUMNS + 1, 127));
   endfunction

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------
   task automatic test_directed();
      // default count after reset: a short matrix closed mid-row
      offer_cell(1'b1, 1'b0);
      offer_cell(1'b1, 1'b1);
      settle_block();

      // count zero acts as one column
      set_column_count('0);
      offer_cell(1'b1, 1'b0);
      offer_cell(1'b1, 1'b0);
      offer_cell(1'b1, 1'b1);
      settle_block();

      // count past the array acts as the full width; empty cell in the middle
      set_column_count('1);
      offer_cell(1'b1, 1'b0);
      offer_cell(1'b0, 1'b0);
      offer_cell(1'b1, 1'b1);
      settle_block();

      // equal heights merge; a lower height pops and inherits the start column
      set_column_count(mrbm_pkg::csr_type'(4));
      offer_cell(1'b1, 1'b0);
      offer_cell(1'b1, 1'b0);
      offer_cell(1'b1, 1'b0);
      offer_cell(1'b1, 1'b0);
      offer_cell(1'b0, 1'b0);
      offer_cell(1'b1, 1'b0);
      offer_cell(1'b1, 1'b0);
      offer_cell(1'b0, 1'b1);
      settle_block();

      // count lowered mid-row: the next cell ends the row at once
      set_column_count(mrbm_pkg::csr_type'(5));
      offer_cell(1'b1, 1'b0);
      offer_cell(1'b1, 1'b0);
      offer_cell(1'b1, 1'b0);
      settle_block();
      set_column_count(mrbm_pkg::csr_type'(2));
      offer_cell(1'b1, 1'b0);
      offer_cell(1'b1, 1'b0);
      offer_cell(1'b1, 1'b1);
      settle_block();

      // one empty cell alone
      set_column_count(mrbm_pkg::csr_type'(1));
      offer_cell(1'b0, 1'b1);
      settle_block();
   endtask

   // a single column of ones taller than the height limit
   task automatic test_height_saturation();
      set_column_count(mrbm_pkg::csr_type'(1));
      for (int i = 0; i < ROWS + 6; i++) offer_cell(1'b1, i == ROWS + 5);
      settle_block();
   endtask

   // long hold on results while matrices keep coming, so the next last cell stalls
   task automatic test_result_backpressure();
      int sent;
      sent = 0;
      set_column_count(mrbm_pkg::csr_type'(3));
      @(posedge clock);
      hold_len = HOLD_CYCLES;
      hold_go  = ~hold_go;
      repeat (6) send_matrix(3, sent);
      settle_block();
   endtask

   task automatic test_random_matrices(input int idle_pct, input int stall_pct,
                                       input int cell_budget);
      int                sent;
      mrbm_pkg::csr_type count;
      int unsigned       cols;
      int unsigned       partial;
      sender_idle_pct = idle_pct;
      rsp_stall_pct   = stall_pct;
      sent = 0;
      while (sent < cell_budget) begin
         settle_block();
         count = pick_column_count();
         cols  = active_columns(count);
         set_column_count(count);
         repeat ($urandom_range(1, 4)) send_matrix(cols, sent);
         // leave a partial row open so the next count may land mid-row
         if ($urandom_range(99) < 20) begin
            partial = $urandom_range(1, cols);
            for (int unsigned i = partial; i > 0; i--)
               offer_cell(1'($urandom_range(1)), 1'b0);
            sent += partial;
         end
      end
      settle_block();
   endtask

   // ---------------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------------
   initial begin
      clear_profile();
      cols_reg = mrbm_pkg::CSR_RESET;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed();
      test_height_saturation();
      test_result_backpressure();
      test_random_matrices(0, 0, 130);
      test_random_matrices(88, 0, 130);
      test_random_matrices(0, 88, 130);
      test_random_matrices(23, 23, 130);

      if (failures == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   // hang guard, far past the slowest legal run
   initial begin
      #50_000_000;
      $display("Regression FAIL");
      $finish;
   end

endmodule
